>>> hw/rtl/uifb_pkg.sv
// ----------------------------------------------------------------------------
// uifb_pkg
// Types and constants shared by the UDP/IPv4 frame builder modules.
// ----------------------------------------------------------------------------
package uifb_pkg;

    localparam int HDR_BYTES = 42;
    localparam int IDX_W     = 6;

    localparam logic [IDX_W-1:0] IDX_HDR_LAST = IDX_W'(HDR_BYTES - 1);
    localparam logic [IDX_W-1:0] IDX_PAYLOAD  = IDX_W'(HDR_BYTES);

    localparam logic [7:0]  ETH_TYPE_HI   = 8'h08;
    localparam logic [7:0]  IP_VER_IHL    = 8'h45;
    localparam logic [15:0] IP_ID         = 16'd3347;
    localparam logic [7:0]  IP_FLAGS_HI   = 8'h40;
    localparam logic [7:0]  IP_TTL        = 8'h80;
    localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
    localparam logic [15:0] IP_HDR_BYTES  = 16'd20;
    localparam logic [15:0] UDP_HDR_BYTES = 16'd8;

    // Sum of the constant 16-bit words of the IPv4 header.
    localparam logic [18:0] IP_CONST_SUM = 19'({IP_VER_IHL, 8'h00}) + 19'(IP_ID)
                                         + 19'({IP_FLAGS_HI, 8'h00})
                                         + 19'({IP_TTL, IP_PROTO_UDP});

    typedef struct packed {
        logic [31:0] source_address;
        logic [31:0] dest_address;
        logic [15:0] source_port_value;
        logic [15:0] dest_port_value;
        logic [15:0] ip_length;
        logic [15:0] udp_length;
        logic [15:0] checksum;
    } hdr_fields_t;

endpackage

>>> hw/rtl/uifb_hdr_gen.sv
// ----------------------------------------------------------------------------
// uifb_hdr_gen
// Selects one byte of the 42-byte Ethernet/IPv4/UDP header by its index.
// ----------------------------------------------------------------------------
module uifb_hdr_gen
    import uifb_pkg::*;
(
    input  hdr_fields_t      fields,
    input  logic [IDX_W-1:0] idx,
    output logic [7:0]       hdr_byte
);

    always_comb begin
        case (idx)
            6'd12:   hdr_byte = ETH_TYPE_HI;
            6'd14:   hdr_byte = IP_VER_IHL;
            6'd16:   hdr_byte = fields.ip_length[15:8];
            6'd17:   hdr_byte = fields.ip_length[7:0];
            6'd18:   hdr_byte = IP_ID[15:8];
            6'd19:   hdr_byte = IP_ID[7:0];
            6'd20:   hdr_byte = IP_FLAGS_HI;
            6'd22:   hdr_byte = IP_TTL;
            6'd23:   hdr_byte = IP_PROTO_UDP;
            6'd24:   hdr_byte = fields.checksum[15:8];
            6'd25:   hdr_byte = fields.checksum[7:0];
            6'd26:   hdr_byte = fields.source_address[31:24];
            6'd27:   hdr_byte = fields.source_address[23:16];
            6'd28:   hdr_byte = fields.source_address[15:8];
            6'd29:   hdr_byte = fields.source_address[7:0];
            6'd30:   hdr_byte = fields.dest_address[31:24];
            6'd31:   hdr_byte = fields.dest_address[23:16];
            6'd32:   hdr_byte = fields.dest_address[15:8];
            6'd33:   hdr_byte = fields.dest_address[7:0];
            6'd34:   hdr_byte = fields.source_port_value[15:8];
            6'd35:   hdr_byte = fields.source_port_value[7:0];
            6'd36:   hdr_byte = fields.dest_port_value[15:8];
            6'd37:   hdr_byte = fields.dest_port_value[7:0];
            6'd38:   hdr_byte = fields.udp_length[15:8];
            6'd39:   hdr_byte = fields.udp_length[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

endmodule

>>> hw/rtl/udp_ipv4_frame_builder_core.sv
// ----------------------------------------------------------------------------
// udp_ipv4_frame_builder_core
// Wraps a stream of UDP payload bytes into an Ethernet/IPv4/UDP frame.
// ----------------------------------------------------------------------------
// Payload bytes pass from the input straight into the output register and
// stream at one byte per cycle while the output is not stalled. A request that
// opens a frame is captured into the header registers with no output byte
// alongside, and then the 42 header bytes leave at one per cycle from a byte
// counter, followed by the request's own byte if it has one; input is held
// off during that burst. Output stalls hold the pipeline. A payload length
// above MAX_PAYLOAD raises too_long on every byte of that frame.
module udp_ipv4_frame_builder_core
    import uifb_pkg::*;
#(
    parameter int unsigned MAX_PAYLOAD = 470
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_first_of_frame,
    input  logic        s_has_byte,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_end_of_frame,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,
    input  logic [15:0] s_source_port_value,
    input  logic [15:0] s_dest_port_value,
    input  logic [15:0] s_payload_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_frame_byte,
    output logic        m_frame_last,
    output logic        m_too_long
);

    logic             hdr_active_reg, hdr_active_next;
    logic [IDX_W-1:0] hdr_idx_reg, hdr_idx_next;
    logic             frame_open_reg, frame_open_next;
    logic             length_flag_reg, length_flag_next;
    logic             m_valid_reg, m_valid_next;
    logic [7:0]       m_byte_reg, m_byte_next;
    logic             m_last_reg, m_last_next;
    logic             m_flag_reg, m_flag_next;

    hdr_fields_t      fields_reg;
    logic [18:0]      sum_reg;
    logic [7:0]       first_byte_reg;
    logic             first_has_reg;
    logic             first_eof_reg;

    logic             advance;
    logic             accept;
    logic             capture;
    logic [15:0]      ip_length;
    logic [16:0]      fold1;
    logic [15:0]      fold2;
    hdr_fields_t      gen_fields;
    logic [7:0]       hdr_byte;

    assign advance = !m_valid_reg || m_ready;
    assign s_ready = !hdr_active_reg && advance;
    assign accept  = s_valid && s_ready;
    assign capture = accept && s_first_of_frame;

    assign ip_length = s_payload_length + IP_HDR_BYTES + UDP_HDR_BYTES;

    // Ones-complement end-around folds of the registered partial sum.
    assign fold1 = 17'(sum_reg[15:0]) + 17'(sum_reg[18:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    always_comb begin
        gen_fields          = fields_reg;
        gen_fields.checksum = ~fold2;
    end

    uifb_hdr_gen u_hdr_gen (
        .fields   (gen_fields),
        .idx      (hdr_idx_reg),
        .hdr_byte (hdr_byte)
    );

    always_comb begin
        hdr_active_next  = hdr_active_reg;
        hdr_idx_next     = hdr_idx_reg;
        frame_open_next  = frame_open_reg;
        length_flag_next = length_flag_reg;
        m_valid_next     = m_valid_reg;
        m_byte_next      = m_byte_reg;
        m_last_next      = m_last_reg;
        m_flag_next      = m_flag_reg;

        if (advance) begin
            m_valid_next = 1'b0;
            if (hdr_active_reg) begin
                m_valid_next = 1'b1;
                m_flag_next  = length_flag_reg;
                if (hdr_idx_reg == IDX_PAYLOAD) begin
                    m_byte_next     = first_byte_reg;
                    m_last_next     = first_eof_reg;
                    hdr_active_next = 1'b0;
                end else begin
                    m_byte_next  = hdr_byte;
                    m_last_next  = 1'b0;
                    hdr_idx_next = hdr_idx_reg + IDX_W'(1);
                    if (hdr_idx_reg == IDX_HDR_LAST && !first_has_reg) begin
                        m_last_next     = first_eof_reg;
                        hdr_active_next = 1'b0;
                    end
                end
            end else if (capture) begin
                hdr_active_next  = 1'b1;
                hdr_idx_next     = '0;
                frame_open_next  = !s_end_of_frame;
                length_flag_next = s_payload_length > 16'(MAX_PAYLOAD);
            end else if (accept && frame_open_reg) begin
                if (s_has_byte) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = s_payload_byte;
                    m_last_next  = s_end_of_frame;
                    m_flag_next  = length_flag_reg;
                end
                if (s_end_of_frame) begin
                    frame_open_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_active_reg  <= 1'b0;
            hdr_idx_reg     <= '0;
            frame_open_reg  <= 1'b0;
            length_flag_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            hdr_active_reg  <= hdr_active_next;
            hdr_idx_reg     <= hdr_idx_next;
            frame_open_reg  <= frame_open_next;
            length_flag_reg <= length_flag_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_byte_reg <= m_byte_next;
        m_last_reg <= m_last_next;
        m_flag_reg <= m_flag_next;
        if (capture) begin
            fields_reg.source_address    <= s_source_address;
            fields_reg.dest_address      <= s_dest_address;
            fields_reg.source_port_value <= s_source_port_value;
            fields_reg.dest_port_value   <= s_dest_port_value;
            fields_reg.ip_length         <= ip_length;
            fields_reg.udp_length        <= s_payload_length + UDP_HDR_BYTES;
            fields_reg.checksum          <= '0;
            sum_reg <= IP_CONST_SUM + 19'(ip_length)
                     + 19'(s_source_address[31:16]) + 19'(s_source_address[15:0])
                     + 19'(s_dest_address[31:16]) + 19'(s_dest_address[15:0]);
            first_byte_reg <= s_payload_byte;
            first_has_reg  <= s_has_byte;
            first_eof_reg  <= s_end_of_frame;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_frame_byte = m_byte_reg;
    assign m_frame_last = m_last_reg;
    assign m_too_long   = m_flag_reg;

    a_no_input_in_header: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_active_reg |-> !s_ready)
        else $error("Input accepted during header burst.");

    a_header_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_first_of_frame |=> hdr_active_reg && hdr_idx_reg == '0)
        else $error("Frame start did not begin a header burst.");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hdr_active_reg |-> hdr_idx_reg <= IDX_PAYLOAD)
        else $error("Header index out of range.");

    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_frame_last |-> !frame_open_reg)
        else $error("Frame still open after its last byte.");

endmodule

>>> tb/uifb_frame_checker.sv
// ----------------------------------------------------------------------------
// uifb_frame_checker
// Watches both channels of the UDP/IPv4 frame builder, predicts every frame
// byte from the accepted requests and compares the bytes that leave the block.
// ----------------------------------------------------------------------------
module uifb_frame_checker #(
    parameter int unsigned MAX_PAYLOAD = 470
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_first_of_frame,
    input  logic        s_has_byte,
    input  logic [7:0]  s_payload_byte,
    input  logic        s_end_of_frame,
    input  logic [31:0] s_source_address,
    input  logic [31:0] s_dest_address,
    input  logic [15:0] s_source_port_value,
    input  logic [15:0] s_dest_port_value,
    input  logic [15:0] s_payload_length,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_frame_byte,
    input  logic        m_frame_last,
    input  logic        m_too_long,
    output int          fail_count,
    output int          pending_count,
    output int          bytes_checked,
    output int          frames_started
);

    localparam int         FRAME_HDR_LEN = 42;
    localparam logic [15:0] IPV4_ID      = 16'd3347;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
        logic       too_long;
    } frame_out_t;

    frame_out_t expected_bytes[$];
    frame_out_t want;
    logic       frame_open_q;
    logic       oversize_q;

    function automatic logic [15:0] ipv4_checksum(input logic [15:0] ip_len,
                                                  input logic [31:0] src,
                                                  input logic [31:0] dst);
        logic [31:0] sum;
        sum = 32'h4500 + 32'(ip_len) + 32'(IPV4_ID) + 32'h4000 + 32'h8011
            + 32'(src[31:16]) + 32'(src[15:0]) + 32'(dst[31:16]) + 32'(dst[15:0]);
        sum = (sum >> 16) + (sum & 32'hffff);
        sum = sum + (sum >> 16);
        return ~sum[15:0];
    endfunction

    function automatic logic [7:0] header_byte(input int idx,
                                               input logic [31:0] src,
                                               input logic [31:0] dst,
                                               input logic [15:0] sport,
                                               input logic [15:0] dport,
                                               input logic [15:0] ip_len,
                                               input logic [15:0] udp_len,
                                               input logic [15:0] csum);
        case (idx)
            12: return 8'h08;
            14: return 8'h45;
            16: return ip_len[15:8];
            17: return ip_len[7:0];
            18: return IPV4_ID[15:8];
            19: return IPV4_ID[7:0];
            20: return 8'h40;
            22: return 8'h80;
            23: return 8'd17;
            24: return csum[15:8];
            25: return csum[7:0];
            26: return src[31:24];
            27: return src[23:16];
            28: return src[15:8];
            29: return src[7:0];
            30: return dst[31:24];
            31: return dst[23:16];
            32: return dst[15:8];
            33: return dst[7:0];
            34: return sport[15:8];
            35: return sport[7:0];
            36: return dport[15:8];
            37: return dport[7:0];
            38: return udp_len[15:8];
            39: return udp_len[7:0];
            default: return 8'h00;
        endcase
    endfunction

    function automatic void predict_frame_bytes();
        logic [15:0] ip_len;
        logic [15:0] udp_len;
        logic [15:0] csum;
        logic        last;
        if (s_first_of_frame) begin
            ip_len     = s_payload_length + 16'd28;
            udp_len    = s_payload_length + 16'd8;
            csum       = ipv4_checksum(ip_len, s_source_address, s_dest_address);
            oversize_q = (32'(s_payload_length) > MAX_PAYLOAD);
            for (int i = 0; i < FRAME_HDR_LEN; i++) begin
                last = s_end_of_frame && !s_has_byte && (i == FRAME_HDR_LEN - 1);
                expected_bytes.push_back('{header_byte(i, s_source_address,
                                                       s_dest_address,
                                                       s_source_port_value,
                                                       s_dest_port_value,
                                                       ip_len, udp_len, csum),
                                           last, oversize_q});
            end
            if (s_has_byte) begin
                expected_bytes.push_back('{s_payload_byte, s_end_of_frame, oversize_q});
            end
            frame_open_q = !s_end_of_frame;
            frames_started++;
        end else if (frame_open_q) begin
            if (s_has_byte) begin
                expected_bytes.push_back('{s_payload_byte, s_end_of_frame, oversize_q});
            end
            if (s_end_of_frame) begin
                frame_open_q = 1'b0;
            end
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_bytes.delete();
            frame_open_q   = 1'b0;
            oversize_q     = 1'b0;
            fail_count     = 0;
            bytes_checked  = 0;
            frames_started = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    $error("unexpected frame byte %02h (frame_last %0b, too_long %0b)",
                           m_frame_byte, m_frame_last, m_too_long);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    bytes_checked++;
                    if (m_frame_byte !== want.frame_byte) begin
                        $error("frame_byte: expected %02h, got %02h",
                               want.frame_byte, m_frame_byte);
                        fail_count++;
                    end
                    if (m_frame_last !== want.frame_last) begin
                        $error("frame_last: expected %0b, got %0b",
                               want.frame_last, m_frame_last);
                        fail_count++;
                    end
                    if (m_too_long !== want.too_long) begin
                        $error("too_long: expected %0b, got %0b",
                               want.too_long, m_too_long);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_frame_bytes();
            end
        end
        pending_count = expected_bytes.size();
    end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the UDP/IPv4 frame builder under several patterns of
// sender gaps and receiver stalls, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module testbench;

    localparam int unsigned MAX_PAYLOAD = 470;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_ITEMS = 70;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_first_of_frame;
    logic        s_has_byte;
    logic [7:0]  s_payload_byte;
    logic        s_end_of_frame;
    logic [31:0] s_source_address;
    logic [31:0] s_dest_address;
    logic [15:0] s_source_port_value;
    logic [15:0] s_dest_port_value;
    logic [15:0] s_payload_length;
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_frame_byte;
    logic        m_frame_last;
    logic        m_too_long;

    int fail_count;
    int pending_count;
    int bytes_checked;
    int frames_started;

    int cycle_count = 0;
    int snd_idle    = 0;
    int rcv_stall   = 0;
    int hold_len    = 0;
    int frame_items = 0;
    int requests    = 0;
    bit open_in_tb  = 1'b0;

    udp_ipv4_frame_builder_core #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_of_frame   (s_first_of_frame),
        .s_has_byte         (s_has_byte),
        .s_payload_byte     (s_payload_byte),
        .s_end_of_frame     (s_end_of_frame),
        .s_source_address   (s_source_address),
        .s_dest_address     (s_dest_address),
        .s_source_port_value(s_source_port_value),
        .s_dest_port_value  (s_dest_port_value),
        .s_payload_length   (s_payload_length),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_byte       (m_frame_byte),
        .m_frame_last       (m_frame_last),
        .m_too_long         (m_too_long)
    );

    uifb_frame_checker #(
        .MAX_PAYLOAD(MAX_PAYLOAD)
    ) frame_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_first_of_frame   (s_first_of_frame),
        .s_has_byte         (s_has_byte),
        .s_payload_byte     (s_payload_byte),
        .s_end_of_frame     (s_end_of_frame),
        .s_source_address   (s_source_address),
        .s_dest_address     (s_dest_address),
        .s_source_port_value(s_source_port_value),
        .s_dest_port_value  (s_dest_port_value),
        .s_payload_length   (s_payload_length),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_frame_byte       (m_frame_byte),
        .m_frame_last       (m_frame_last),
        .m_too_long         (m_too_long),
        .fail_count         (fail_count),
        .pending_count      (pending_count),
        .bytes_checked      (bytes_checked),
        .frames_started     (frames_started)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("udp_ipv4_frame_builder_core: mismatch");
            $finish;
        end
    end

    // The long hold-off is counted here so the sender keeps offering meanwhile.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                hold_len--;
            end else begin
                m_ready <= ($urandom_range(99) >= rcv_stall);
            end
        end
    end

    task automatic send_request(input logic first, input logic has, input logic [7:0] data,
                                input logic eof, input logic [31:0] src,
                                input logic [31:0] dst, input logic [15:0] sport,
                                input logic [15:0] dport, input logic [15:0] len);
        while ($urandom_range(99) < snd_idle) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid             <= 1'b1;
        s_first_of_frame    <= first;
        s_has_byte          <= has;
        s_payload_byte      <= data;
        s_end_of_frame      <= eof;
        s_source_address    <= src;
        s_dest_address      <= dst;
        s_source_port_value <= sport;
        s_dest_port_value   <= dport;
        s_payload_length    <= len;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests++;
        if (first || open_in_tb) begin
            frame_items++;
        end
        if (first) begin
            open_in_tb = !eof;
        end else if (eof) begin
            open_in_tb = 1'b0;
        end
    endtask

    task automatic send_payload(input logic has, input logic [7:0] data, input logic eof);
        send_request(1'b0, has, data, eof, $urandom, $urandom, 16'($urandom),
                     16'($urandom), 16'($urandom));
    endtask

    task automatic send_random_frame();
        int          choice;
        int          more;
        logic [15:0] len;
        logic        start_has;
        choice = $urandom_range(99);
        if (choice < 65) begin
            len = 16'($urandom_range(0, 60));
        end else if (choice < 75) begin
            len = 16'($urandom_range(471, 2000));
        end else if (choice < 82) begin
            len = 16'($urandom_range(65500, 65535));
        end else if (choice < 88) begin
            len = 16'($urandom_range(470, 471));
        end else begin
            len = 16'($urandom_range(0, 65535));
        end
        if ($urandom_range(99) < 6) begin
            send_payload(1'($urandom), 8'($urandom), 1'($urandom));
        end
        more      = $urandom_range(0, 6);
        start_has = ($urandom_range(9) != 0);
        send_request(1'b1, start_has, 8'($urandom), more == 0, $urandom, $urandom,
                     16'($urandom), 16'($urandom), len);
        for (int i = 1; i <= more; i++) begin
            // Now and then a frame is left open so the next start restarts it.
            if (i == more && $urandom_range(99) < 10) begin
                break;
            end
            send_payload($urandom_range(9) != 0, 8'($urandom), i == more);
        end
    endtask

    initial begin
        int target;
        aresetn             = 1'b0;
        s_valid             = 1'b0;
        s_first_of_frame    = 1'b0;
        s_has_byte          = 1'b0;
        s_payload_byte      = 8'h00;
        s_end_of_frame      = 1'b0;
        s_source_address    = 32'h0;
        s_dest_address      = 32'h0;
        s_source_port_value = 16'h0;
        s_dest_port_value   = 16'h0;
        s_payload_length    = 16'h0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Requests with no open frame are dropped.
        send_payload(1'b1, 8'ha5, 1'b0);
        send_payload(1'b0, 8'h00, 1'b1);
        // Single-byte frame and an empty frame that ends on its header.
        send_request(1'b1, 1'b1, 8'h00, 1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 16'd1);
        send_request(1'b1, 1'b0, 8'hff, 1'b1, 32'hffffffff, 32'hffffffff,
                     16'hffff, 16'hffff, 16'd0);
        // Largest length that is not flagged.
        send_request(1'b1, 1'b1, 8'hff, 1'b0, 32'hc0a80001, 32'h0a000002,
                     16'd1234, 16'd80, 16'd470);
        send_payload(1'b1, 8'h00, 1'b0);
        send_payload(1'b0, 8'h5a, 1'b0);
        send_payload(1'b1, 8'hff, 1'b1);
        send_payload(1'b1, 8'h11, 1'b1);
        // Oversize frame closed by a request without a byte.
        send_request(1'b1, 1'b1, 8'h7e, 1'b0, 32'h01020304, 32'h05060708,
                     16'h8000, 16'h0001, 16'd471);
        send_payload(1'b1, 8'h81, 1'b0);
        send_payload(1'b0, 8'h00, 1'b1);
        // Length wrap, then a restart while the frame is still open.
        send_request(1'b1, 1'b0, 8'h00, 1'b0, 32'h80000000, 32'h7fffffff,
                     16'h00ff, 16'hff00, 16'hffff);
        send_payload(1'b1, 8'h3c, 1'b0);
        send_request(1'b1, 1'b1, 8'hc3, 1'b0, 32'hdeadbeef, 32'h12345678,
                     16'h5555, 16'haaaa, 16'd65507);
        send_payload(1'b1, 8'h01, 1'b1);
        send_request(1'b1, 1'b1, 8'h02, 1'b1, 32'h0f0f0f0f, 32'hf0f0f0f0,
                     16'h0f0f, 16'hf0f0, 16'd65508);
        send_request(1'b1, 1'b0, 8'h00, 1'b0, 32'h33333333, 32'hcccccccc,
                     16'h3333, 16'hcccc, 16'd65528);
        send_payload(1'b0, 8'h00, 1'b1);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    snd_idle  = 0;
                    rcv_stall = 0;
                    hold_len  = 400;
                end
                1: begin
                    snd_idle  = 66;
                    rcv_stall = 0;
                end
                2: begin
                    snd_idle  = 0;
                    rcv_stall = 66;
                end
                default: begin
                    snd_idle  = 28;
                    rcv_stall = 28;
                end
            endcase
            target = frame_items + PHASE_ITEMS;
            while (frame_items < target) begin
                send_random_frame();
            end
        end
        s_valid   <= 1'b0;
        rcv_stall = 0;

        while (pending_count != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);

        $display("Run covered %0d requests in %0d frame starts, %0d frame bytes checked.",
                 requests, frames_started, bytes_checked);
        $display("Four gap and stall patterns were used, one with a long output hold-off.");
        if (fail_count == 0) begin
            $display("udp_ipv4_frame_builder_core: match");
        end else begin
            $display("udp_ipv4_frame_builder_core: mismatch");
        end
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/uifb_pkg.sv
hw/rtl/uifb_hdr_gen.sv
hw/rtl/udp_ipv4_frame_builder_core.sv
tb/uifb_frame_checker.sv
tb/testbench.sv
